[rtl/stereo_wave_folder_with_dry_wet_mix_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the stereo wave folder
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef STEREO_WAVE_FOLDER_WITH_DRY_WET_MIX_MACROS_SVH
`define STEREO_WAVE_FOLDER_WITH_DRY_WET_MIX_MACROS_SVH

// Same-cycle implication
`define SWF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SWF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/swf_pkg.sv]
// ----------------------------------------------------------------------------
// swf_pkg
// Constants, sequencer states and shared types of the stereo wave folder.
// ----------------------------------------------------------------------------
`default_nettype none

package swf_pkg;

    // Sample width default and amount register
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int AMT_W           = 11;

    // Quotient bits resolved by the remainder unit; the fold limit never drops
    // below about 0.4 of full scale, so the fold period divides the offset
    // gained sample fewer than four times.
    localparam int FOLD_QBITS = 4;

    localparam logic [AMT_W-1:0] AMOUNT_ONE   = 11'd1024;
    localparam logic [AMT_W-1:0] AMOUNT_RESET = 11'd430;

    // Q.16 coefficients: 3.2, 0.94, 0.54 and 0.05
    localparam logic [17:0] GAIN_K_Q16    = 18'd209715;
    localparam logic [15:0] LIM_BASE_Q16  = 16'd61604;
    localparam logic [15:0] LIM_SLOPE_Q16 = 16'd35389;
    localparam logic [15:0] LIM_FLOOR_Q16 = 16'd3277;

    // Register map: word index taken from paddr[2]
    localparam int          PADDR_W           = 3;
    localparam logic [0:0]  REG_EFFECT_AMOUNT = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DRIVE,
        S_D16,
        S_GAIN,
        S_LIMM,
        S_LIM,
        S_MULX,
        S_ROUNDG,
        S_FOLD_START,
        S_FOLD_WAIT,
        S_MULW,
        S_MIX,
        S_DONE
    } state_t;

    // Status of the remainder unit
    typedef struct packed {
        logic busy;
        logic done;
    } rem_stat_t;

endpackage

`default_nettype wire

[rtl/swf_rem.sv]
// ----------------------------------------------------------------------------
// swf_rem
// Restoring remainder unit: one compare and subtract per cycle over a fixed
// number of quotient bits, used to wrap the gained sample into the fold period.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stereo_wave_folder_with_dry_wet_mix_macros.svh"

module swf_rem #(
    parameter int DW = swf_pkg::SAMPLE_BITS_DEF + 3,
    parameter int QB = swf_pkg::FOLD_QBITS
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DW-1:0]    dividend,
    input  wire logic [DW-1:0]    divisor,
    output swf_pkg::rem_stat_t    stat,
    output logic      [DW-1:0]    rem
);

    import swf_pkg::*;

    localparam int SW = DW + QB - 1;
    localparam int CW = $clog2(QB + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] dvs_reg;
    logic [SW-1:0] sub_reg;
    logic          take;

    assign take = (SW'(rem_reg) >= sub_reg);

    // Control: count down the quotient bits, pulse done after the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QB);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: subtract the shifted divisor where it fits, then shift it down
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            dvs_reg <= divisor;
            sub_reg <= SW'(divisor) << (QB - 1);
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                rem_reg <= rem_reg - DW'(sub_reg);
            end
            sub_reg <= sub_reg >> 1;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign rem       = rem_reg;

    `SWF_ASSERT_IMPLY(a_rem_below_divisor, clk, rst_n, done_reg, rem_reg < dvs_reg, "remainder not below divisor")
    `SWF_ASSERT_NEXT(a_rem_start_loads, clk, rst_n, start, busy_reg && (cnt_reg == CW'(QB)), "start did not load the count")
    `SWF_ASSERT_IMPLY(a_rem_count_live, clk, rst_n, busy_reg, cnt_reg != '0, "busy with empty count")

endmodule

`default_nettype wire

[rtl/stereo_wave_folder_with_dry_wet_mix.sv]
// ----------------------------------------------------------------------------
// stereo_wave_folder_with_dry_wet_mix
// Stereo wave folder with dry/wet blend on a stream of sample pairs.
// ----------------------------------------------------------------------------
// One sample pair is taken while the block is idle; the next pair is accepted
// only once the sequencer has finished this one and returned to idle. The
// single shared multiplier computes drive, gain, limit, gained samples and wet
// steps in turn, and the restoring remainder unit wraps each channel's gained
// sample into the fold period. A finished result waits in the output register,
// so the next pair is accepted while it is stalled. effect_amount is written
// through the configuration port at byte address 0; only its low 11 bits are
// kept, and values above 1024 act as 1024.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stereo_wave_folder_with_dry_wet_mix_macros.svh"

module stereo_wave_folder_with_dry_wet_mix #(
    parameter  int SAMPLE_BITS = swf_pkg::SAMPLE_BITS_DEF,
    localparam int TD_W        = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // Input stream
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [TD_W-1:0]              s_tdata,   // x_in, y_in, zero pad
    // Output stream
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [TD_W-1:0]              m_tdata,   // x_out, y_out, zero pad
    // Configuration
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [swf_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);

    import swf_pkg::*;

    localparam int S     = SAMPLE_BITS;
    localparam int OPA_W = (S + 2 > 20) ? S + 2 : 20;
    localparam int OPB_W = 20;
    localparam int PW    = OPA_W + OPB_W;
    localparam int GW    = S + 3;
    localparam int RW    = S + 3;

    state_t state_reg, state_next;

    logic [AMT_W-1:0]        amt_reg;
    logic [AMT_W-1:0]        a10;
    logic                    ch_reg;
    logic                    m_tvalid_reg;

    logic signed [S-1:0]     dry_x_reg, dry_y_reg, dry_cur;
    logic signed [PW-1:0]    prod_reg;
    logic [16:0]             d16_reg;
    logic [18:0]             gain_reg;
    logic [S-1:0]            lim_reg;
    logic signed [GW-1:0]    gained_reg;
    logic                    neg_reg;
    logic signed [S:0]       fold_reg;
    logic signed [S-1:0]     res_x_reg, res_y_reg;
    logic [S-1:0]            x_out_reg, y_out_reg;

    logic signed [OPA_W-1:0] op_a;
    logic signed [OPB_W-1:0] op_b;

    logic                    wr_en;
    logic                    rem_start;
    logic                    load_out;
    rem_stat_t               rem_stat;
    logic [RW-1:0]           rem_q;

    logic [16:0]             d16_c;
    logic [19:0]             rnd16;
    logic [18:0]             gain_c;
    logic [15:0]             lim16_raw, lim16;
    logic [S+15:0]           lim_wide;
    logic [S-1:0]            lim_c0, lim_c;
    logic [PW-1:0]           mag_c;
    logic [PW-1:0]           q16, q10;
    logic signed [GW-1:0]    gained_c;
    logic signed [GW:0]      w_c;
    logic [RW-1:0]           w_mag;
    logic [RW-1:0]           rem_dvs;
    logic [S+1:0]            per_c, m_c;
    logic signed [S+2:0]     lim_s, m_s, f_c;
    logic signed [S+1:0]     diff_c, step_c;
    logic signed [S+2:0]     sum_c;
    logic [S-1:0]            res_c;

    // Configuration port
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amt_reg <= AMOUNT_RESET;
        end
        else if (wr_en && (paddr[2:2] == REG_EFFECT_AMOUNT))
        begin
            amt_reg <= pwdata[AMT_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2:2] == REG_EFFECT_AMOUNT)
        begin
            prdata = 32'(amt_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    // Clamp the amount to one
    assign a10 = (amt_reg > AMOUNT_ONE) ? AMOUNT_ONE : amt_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:       if (s_tvalid) state_next = S_DRIVE;
            S_DRIVE:      state_next = S_D16;
            S_D16:        state_next = S_GAIN;
            S_GAIN:       state_next = S_LIMM;
            S_LIMM:       state_next = S_LIM;
            S_LIM:        state_next = S_MULX;
            S_MULX:       state_next = S_ROUNDG;
            S_ROUNDG:     state_next = S_FOLD_START;
            S_FOLD_START: state_next = S_FOLD_WAIT;
            S_FOLD_WAIT:  if (rem_stat.done) state_next = S_MULW;
            S_MULW:       state_next = S_MIX;
            S_MIX:        state_next = ch_reg ? S_DONE : S_MULX;
            S_DONE:       if (!m_tvalid_reg || m_tready) state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_tready  = 1'b0;
        rem_start = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            S_IDLE:       s_tready  = 1'b1;
            S_FOLD_START: rem_start = 1'b1;
            S_DONE:       load_out  = !m_tvalid_reg || m_tready;
            default:      ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ch_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE)
            begin
                ch_reg <= 1'b0;
            end
            else if (state_reg == S_MIX)
            begin
                ch_reg <= 1'b1;
            end
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign dry_cur = ch_reg ? dry_y_reg : dry_x_reg;

    // Shared multiplier operands
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            S_DRIVE:
            begin
                op_a = OPA_W'(a10);
                op_b = OPB_W'(a10);
            end
            S_GAIN:
            begin
                op_a = OPA_W'(GAIN_K_Q16);
                op_b = OPB_W'(d16_reg);
            end
            S_LIMM:
            begin
                op_a = OPA_W'(LIM_SLOPE_Q16);
                op_b = OPB_W'(d16_reg);
            end
            S_MULX:
            begin
                op_a = OPA_W'(dry_cur);
                op_b = OPB_W'(gain_reg);
            end
            S_MULW:
            begin
                op_a = OPA_W'(diff_c);
                op_b = OPB_W'(a10);
            end
            default: ;
        endcase
    end

    // Drive, gain and fold limit from the product register
    assign d16_c     = 17'((prod_reg[20:0] + 21'd8) >> 4);
    assign rnd16     = 20'((prod_reg[35:0] + 36'd32768) >> 16);
    assign gain_c    = 19'd65536 + rnd16[18:0];
    assign lim16_raw = LIM_BASE_Q16 - rnd16[15:0];
    assign lim16     = (lim16_raw < LIM_FLOOR_Q16) ? LIM_FLOOR_Q16 : lim16_raw;
    assign lim_wide  = ((S + 16)'(lim16) << (S - 1)) + (S + 16)'(32768);
    assign lim_c0    = S'(lim_wide >> 16);
    assign lim_c     = (lim_c0 == '0) ? S'(1) : lim_c0;

    // Round the signed product half away from zero
    assign mag_c    = prod_reg[PW-1] ? PW'(-prod_reg) : PW'(prod_reg);
    assign q16      = (mag_c + PW'(32768)) >> 16;
    assign q10      = (mag_c + PW'(512)) >> 10;
    assign gained_c = prod_reg[PW-1] ? -GW'(q16) : GW'(q16);

    // Offset by the limit and split into sign and magnitude for the wrap
    assign w_c     = (GW + 1)'(gained_reg) + $signed((GW + 1)'(lim_reg));
    assign w_mag   = RW'(w_c[GW] ? -w_c : w_c);
    assign rem_dvs = RW'({lim_reg, 2'b00});

    // Floor modulo, then reflect about the limit
    assign per_c = (S + 2)'({lim_reg, 2'b00});
    assign m_c   = (neg_reg && (rem_q != '0)) ? per_c - (S + 2)'(rem_q) : (S + 2)'(rem_q);
    assign lim_s = $signed((S + 3)'(lim_reg));
    assign m_s   = $signed((S + 3)'(m_c));
    assign f_c   = (m_c <= (S + 2)'({lim_reg, 1'b0})) ? m_s - lim_s
                                                      : lim_s + lim_s + lim_s - m_s;

    // Wet step and saturating mix
    assign diff_c = (S + 2)'(fold_reg) - (S + 2)'(dry_cur);
    assign step_c = prod_reg[PW-1] ? -(S + 2)'(q10) : (S + 2)'(q10);
    assign sum_c  = (S + 3)'(dry_cur) + (S + 3)'(step_c);

    always_comb
    begin
        if ((sum_c[S+2:S-1] == '0) || (sum_c[S+2:S-1] == '1))
        begin
            res_c = sum_c[S-1:0];
        end
        else if (sum_c[S+2])
        begin
            res_c = {1'b1, {(S - 1){1'b0}}};
        end
        else
        begin
            res_c = {1'b0, {(S - 1){1'b1}}};
        end
    end

    // Datapath registers; hold both channel results until the output frees up
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    dry_x_reg <= s_tdata[S-1:0];
                    dry_y_reg <= s_tdata[2*S-1:S];
                end
            end
            S_D16:        d16_reg    <= d16_c;
            S_LIMM:       gain_reg   <= gain_c;
            S_LIM:        lim_reg    <= lim_c;
            S_ROUNDG:     gained_reg <= gained_c;
            S_FOLD_START: neg_reg    <= w_c[GW];
            S_FOLD_WAIT:  if (rem_stat.done) fold_reg <= (S + 1)'(f_c);
            S_MIX:        if (!ch_reg) res_x_reg <= res_c; else res_y_reg <= res_c;
            S_DONE:
            begin
                if (load_out)
                begin
                    x_out_reg <= res_x_reg;
                    y_out_reg <= res_y_reg;
                end
            end
            default: ;
        endcase
    end

    // Wrap unit
    swf_rem #(
        .DW (RW),
        .QB (FOLD_QBITS)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (w_mag),
        .divisor  (rem_dvs),
        .stat     (rem_stat),
        .rem      (rem_q)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TD_W'({y_out_reg, x_out_reg});

    `SWF_ASSERT_IMPLY(a_done_in_wait, clk, rst_n, rem_stat.done, state_reg == S_FOLD_WAIT, "wrap result outside wait state")
    `SWF_ASSERT_IMPLY(a_fold_in_limit, clk, rst_n, state_reg == S_MULW, (fold_reg <= $signed((S + 1)'(lim_reg))) && (fold_reg >= -$signed((S + 1)'(lim_reg))), "folded sample beyond limit")
    `SWF_ASSERT_IMPLY(a_wrap_setup, clk, rst_n, state_reg == S_FOLD_START, (lim_reg != '0) && (gain_reg >= 19'd65536) && !rem_stat.busy, "wrap started with bad setup")

endmodule

`default_nettype wire

[tb/stereo_wave_folder_with_dry_wet_mix_test.sv]
// ----------------------------------------------------------------------------
// Stereo wave folder testbench
// Streams sample pairs through the folder under several effect amounts and
// compares every output beat with a bit-exact fixed-point model of the fold
// and the dry/wet blend. Both stream sides pause and stall at random.
// ----------------------------------------------------------------------------
module stereo_wave_folder_with_dry_wet_mix_test;

    import swf_pkg::*;

    // Register map and timing
    localparam logic [PADDR_W-1:0] AMOUNT_ADDR   = {REG_EFFECT_AMOUNT, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = 3'd4;
    localparam int                 SETTLE_CYCLES = 2 * FOLD_QBITS + 24;

    // Fixed-point coefficients of the fold (unity in Q.10, the rest Q.16)
    localparam longint UNITY_Q10       = 1024;
    localparam longint GAIN_Q16        = 209715;
    localparam longint LIMIT_BASE_Q16  = 61604;
    localparam longint LIMIT_SLOPE_Q16 = 35389;
    localparam longint LIMIT_FLOOR_Q16 = 3277;

    typedef struct {
        logic [15:0] x_dry;
        logic [15:0] y_dry;
        logic [15:0] x_wet;
        logic [15:0] y_wet;
    } pair_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;     // x_in, y_in
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // x_out, y_out
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr  = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Model state and bookkeeping
    logic [10:0] amount_q10 = AMOUNT_RESET;
    pair_t       pending_pairs[$];
    pair_t       oldest;
    bit          idle_on        = 1'b1;
    int          stall_left     = 0;
    int          mismatch_count = 0;
    int          pairs_sent     = 0;
    int          pairs_checked  = 0;
    int          amount_writes  = 0;

    stereo_wave_folder_with_dry_wet_mix DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // Divide by 2^sh, rounding half away from zero
    function automatic longint round_shift(input longint p, input int sh);
        longint mag;
        mag = (p < 0) ? -p : p;
        mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
        return (p < 0) ? -mag : mag;
    endfunction

    // Gain, fold about +/-limit, then blend with the dry sample
    function automatic logic [15:0] fold_and_blend(input logic [15:0] raw,
                                                   input logic [10:0] amt);
        longint a;
        longint drive;
        longint gain;
        longint lim_q16;
        longint lim;
        longint dry;
        longint gained;
        longint period;
        longint m;
        longint folded;
        longint mixed;
        a       = (amt > UNITY_Q10) ? UNITY_Q10 : longint'(amt);
        drive   = (a * a + 8) >>> 4;
        gain    = 65536 + ((GAIN_Q16 * drive + 32768) >>> 16);
        lim_q16 = LIMIT_BASE_Q16 - ((LIMIT_SLOPE_Q16 * drive + 32768) >>> 16);
        if (lim_q16 < LIMIT_FLOOR_Q16)
            lim_q16 = LIMIT_FLOOR_Q16;
        lim = ((lim_q16 << 15) + 32768) >>> 16;
        if (lim < 1)
            lim = 1;
        dry    = longint'($signed(raw));
        gained = round_shift(dry * gain, 16);
        period = 4 * lim;
        m      = (gained + lim) % period;
        if (m < 0)
            m += period;
        folded = (m <= 2 * lim) ? m - lim : 3 * lim - m;
        mixed  = dry + round_shift((folded - dry) * a, 10);
        if (mixed > 32767)
            mixed = 32767;
        if (mixed < -32768)
            mixed = -32768;
        return mixed[15:0];
    endfunction

    // Random sample, weighted toward the ranges where folding differs
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 4095) - 2048);
            1:       return 16'(32767 - $urandom_range(0, 255));
            2:       return 16'(-32768 + $urandom_range(0, 255));
            3:       return 16'($urandom_range(0, 2) - 1);
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task automatic check_channel(input string chan, input logic [15:0] dry,
                                 input logic [15:0] got, input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: dry %0d amount %0d got %0d want %0d",
                chan, $signed(dry), amount_q10, $signed(got), $signed(want)));
    endtask

    // Check each output beat against the oldest pending pair, then pick the
    // ready level for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_pairs.size() == 0)
                report_mismatch($sformatf("output beat %h with no pair pending", m_tdata));
            else
            begin
                oldest = pending_pairs.pop_front();
                check_channel("x_out", oldest.x_dry, m_tdata[15:0], oldest.x_wet);
                check_channel("y_out", oldest.y_dry, m_tdata[31:16], oldest.y_wet);
                pairs_checked++;
            end
        end
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 19) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Send one pair, with an occasional gap before it
    task automatic send_pair(input logic [15:0] x_dry, input logic [15:0] y_dry);
        pair_t item;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y_dry, x_dry};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        item.x_dry = x_dry;
        item.y_dry = y_dry;
        item.x_wet = fold_and_blend(x_dry, amount_q10);
        item.y_wet = fold_and_blend(y_dry, amount_q10);
        pending_pairs.insert(pending_pairs.size(), item);
        pairs_sent++;
    endtask

    // Drop valid and wait until every pending pair has come out
    task automatic drain_pairs();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_pairs.size() != 0)
            @(posedge clk);
    endtask

    // Register write, only with the block idle
    task automatic write_amount(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
        drain_pairs();
        repeat (SETTLE_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == AMOUNT_ADDR)
            amount_q10 = value[10:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        amount_writes++;
        @(posedge clk);
    endtask

    task automatic read_amount();
        psel   <= 1'b1;
        pwrite <= 1'b0;
        paddr  <= AMOUNT_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {21'd0, amount_q10})
            report_mismatch($sformatf("amount readback %0d want %0d", prdata, amount_q10));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Reset amount: extremes and zero crossings of both channels
    task automatic test_reset_amount();
        read_amount();
        send_pair(16'h8000, 16'h7FFF);
        send_pair(16'h7FFF, 16'h8000);
        send_pair(16'h0000, 16'hFFFF);
        send_pair(16'h0001, 16'h0000);
        send_pair(16'h4000, 16'hC000);
        send_pair(16'd30000, -16'sd30000);
        send_pair(16'd12000, 16'd20000);
    endtask

    // Zero amount passes the input through
    task automatic test_amount_zero();
        write_amount(AMOUNT_ADDR, 32'd0);
        read_amount();
        send_pair(16'h8000, 16'h7FFF);
        send_pair(16'h1234, 16'hEDCC);
        send_pair(16'hFFFF, 16'h0001);
    endtask

    // Unity, above unity (upper bus bits set), smallest and just below unity
    task automatic test_amount_extremes();
        write_amount(AMOUNT_ADDR, 32'd1024);
        send_pair(16'h7FFF, 16'h8000);
        send_pair(16'd3000, -16'sd9000);
        write_amount(AMOUNT_ADDR, 32'hFFFF_FFFF);
        read_amount();
        send_pair(16'h7FFF, 16'h8000);
        send_pair(16'd3000, -16'sd9000);
        write_amount(AMOUNT_ADDR, 32'd1);
        send_pair(16'h7FFF, 16'h8000);
        send_pair(16'd25000, 16'h0000);
        write_amount(AMOUNT_ADDR, 32'd1023);
        send_pair(16'h8000, 16'h7FFF);
        send_pair(16'd18000, -16'sd18000);
    endtask

    // A write outside the register map leaves the amount alone
    task automatic test_unmapped_write();
        write_amount(ADDR_UNMAPPED, 32'd0);
        read_amount();
        send_pair(16'h7FFF, 16'd100);
        send_pair(-16'sd100, 16'h8000);
    endtask

    // Long random stream under a range of amounts; the last phase runs flat out
    task automatic test_random_stream();
        logic [31:0] amounts[8];
        amounts = '{32'd430, 32'd0, 32'd1024, 32'd2047,
                    32'($urandom_range(1, 1023)), 32'($urandom_range(0, 2047)),
                    32'd512, 32'($urandom_range(0, 1100))};
        for (int p = 0; p < 8; p++)
        begin
            if (p == 7)
                idle_on = 1'b0;
            write_amount(AMOUNT_ADDR, amounts[p]);
            for (int i = 0; i < 128; i++)
            begin
                // hold the sender until the folder has emptied once
                if (p == 3 && i == 64)
                    drain_pairs();
                send_pair(pick_sample(), pick_sample());
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_amount();
        test_amount_zero();
        test_amount_extremes();
        test_unmapped_write();
        test_random_stream();
        drain_pairs();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Checked %0d of %0d sample pairs over %0d register writes,", pairs_checked,
                 pairs_sent, amount_writes);
        $display("covering zero, unity, above-unity and reset amounts with random stalls.");
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Hard limit on the run
    initial
    begin
        #5000000;
        $display("Timeout with %0d pairs still pending", pending_pairs.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
